// ----- rtl/lvm_pkg.sv -----
// shared beat types and constants for the look-at view matrix block
package lvm_pkg;

	localparam int Q_W = 32;

	typedef struct packed {
		logic signed [Q_W-1:0] eye_x;
		logic signed [Q_W-1:0] eye_y;
		logic signed [Q_W-1:0] eye_z;
		logic signed [Q_W-1:0] target_x;
		logic signed [Q_W-1:0] target_y;
		logic signed [Q_W-1:0] target_z;
		logic signed [Q_W-1:0] up_x;
		logic signed [Q_W-1:0] up_y;
		logic signed [Q_W-1:0] up_z;
	} cam_t;

	typedef struct packed {
		logic [1:0]            row_index;
		logic signed [Q_W-1:0] col0;
		logic signed [Q_W-1:0] col1;
		logic signed [Q_W-1:0] col2;
		logic signed [Q_W-1:0] col3;
		logic                  last_row;
		logic                  degenerate;
	} row_t;

	// row codes of the emitted matrix
	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;
	localparam logic [1:0] ROW_W = 2'd3;

	// scaled magnitudes are brought into [2^29, 2^30) before the square root
	localparam int NORM_TOP = 29;
	localparam int NORM_W   = 30;
	// square root: 64-bit radicand, two bits per step
	localparam int SQRT_W   = 64;
	localparam int SQRT_N   = 32;
	localparam int ROOT_W   = 31;

endpackage

// ----- rtl/lvm_norm.sv -----
// pipelined 3-vector normalizer: scale, sum of squares, square root, divide
module lvm_norm #(
	parameter int IW = 33,
	parameter int OW = 18,
	parameter int F  = 16,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic signed [IW-1:0] vec [3],
	input  logic [SW-1:0]        side,
	output logic                 out_vld,
	output logic signed [OW-1:0] out_vec [3],
	output logic                 ok,
	output logic [SW-1:0]        out_side
);

	localparam int NG  = (IW + 7) / 8;
	localparam int PW  = $clog2(NG * 8);
	localparam int XW  = (IW > lvm_pkg::NORM_W) ? IW : lvm_pkg::NORM_W;
	localparam int MW  = lvm_pkg::NORM_W;
	localparam int SQN = lvm_pkg::SQRT_N;
	localparam int SQW = lvm_pkg::SQRT_W;
	localparam int RW  = lvm_pkg::ROOT_W;
	localparam int QB  = F + 1;
	localparam int DW  = F + 32;

	// stage 1: magnitudes and signs
	logic [IW-1:0] mag_c [3];
	logic          vld_s1;
	logic [2:0]    neg_s1;
	logic [IW-1:0] mag_s1 [3];
	logic [SW-1:0] side_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][IW-1] ? IW'(-vec[i]) : IW'(vec[i]);
		end
	end

	// stage 2: leading one per byte of the or of magnitudes
	logic [NG*8-1:0] orx_c;
	logic [NG-1:0]   any_c;
	logic [2:0]      pos_c [NG];
	logic            vld_s2;
	logic [2:0]      neg_s2;
	logic [IW-1:0]   mag_s2 [3];
	logic [SW-1:0]   side_s2;
	logic [NG-1:0]   any_s2;
	logic [2:0]      pos_s2 [NG];

	always_comb begin
		orx_c = (NG*8)'(mag_s1[0] | mag_s1[1] | mag_s1[2]);
		for (int g = 0; g < NG; g++) begin
			any_c[g] = 1'b0;
			pos_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orx_c[g*8+b]) begin
					any_c[g] = 1'b1;
					pos_c[g] = 3'(b);
				end
			end
		end
	end

	// stage 3: msb position of the largest magnitude
	logic [PW-1:0] msb_c;
	logic          vld_s3;
	logic [2:0]    neg_s3;
	logic [IW-1:0] mag_s3 [3];
	logic [SW-1:0] side_s3;
	logic [PW-1:0] msb_s3;
	logic          nz_s3;

	always_comb begin
		msb_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (any_s2[g]) begin
				msb_c = PW'(g * 8) + PW'(pos_s2[g]);
			end
		end
	end

	// stage 4: scale by a power of two
	logic [XW-1:0]         sh_c [3];
	logic                  vld_s4;
	logic [2:0]            neg_s4;
	logic [2:0][MW-1:0]    sm_s4;
	logic [SW-1:0]         side_s4;
	logic                  nz_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (msb_s3 >= PW'(lvm_pkg::NORM_TOP)) begin
				sh_c[i] = XW'(mag_s3[i]) >> (msb_s3 - PW'(lvm_pkg::NORM_TOP));
			end else begin
				sh_c[i] = XW'(mag_s3[i]) << (PW'(lvm_pkg::NORM_TOP) - msb_s3);
			end
		end
	end

	// stage 5: squares
	logic                  vld_s5;
	logic [2:0]            neg_s5;
	logic [2:0][MW-1:0]    sm_s5;
	logic [SW-1:0]         side_s5;
	logic                  nz_s5;
	logic [2*MW-1:0]       sqr_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][IW-1];
				mag_s1[i] <= mag_c[i];
				mag_s2[i] <= mag_s1[i];
				mag_s3[i] <= mag_s2[i];
				sm_s4[i]  <= nz_s3 ? sh_c[i][MW-1:0] : '0;
				sqr_s5[i] <= (2*MW)'(sm_s4[i]) * (2*MW)'(sm_s4[i]);
			end
			side_s1 <= side;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			any_s2  <= any_c;
			pos_s2  <= pos_c;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
			msb_s3  <= msb_c;
			nz_s3   <= |any_s2;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
			nz_s4   <= nz_s3;
			neg_s5  <= neg_s4;
			side_s5 <= side_s4;
			nz_s5   <= nz_s4;
			sm_s5   <= sm_s4;
		end
	end

	// square root, one result bit per stage; index 0 holds the sum of squares
	logic [SQW-1:0]     rt_v_sk    [SQN+1];
	logic [SQW-1:0]     rt_r_sk    [SQN+1];
	logic [2:0][MW-1:0] rt_m_sk    [SQN+1];
	logic [2:0]         rt_neg_sk  [SQN+1];
	logic               rt_nz_sk   [SQN+1];
	logic [SW-1:0]      rt_side_sk [SQN+1];
	logic               rt_vld_sk  [SQN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_sk[0] <= 1'b0;
		end else if (en) begin
			rt_vld_sk[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_v_sk[0]    <= SQW'(sqr_s5[0]) + SQW'(sqr_s5[1]) + SQW'(sqr_s5[2]);
			rt_r_sk[0]    <= '0;
			rt_m_sk[0]    <= sm_s5;
			rt_neg_sk[0]  <= neg_s5;
			rt_nz_sk[0]   <= nz_s5;
			rt_side_sk[0] <= side_s5;
		end
	end

	for (genvar k = 1; k <= SQN; k++) begin : g_root
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_sk[k] <= 1'b0;
			end else if (en) begin
				rt_vld_sk[k] <= rt_vld_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_v_sk[k-1] >= rt_r_sk[k-1] + BIT) begin
					rt_v_sk[k] <= rt_v_sk[k-1] - rt_r_sk[k-1] - BIT;
					rt_r_sk[k] <= (rt_r_sk[k-1] >> 1) + BIT;
				end else begin
					rt_v_sk[k] <= rt_v_sk[k-1];
					rt_r_sk[k] <= rt_r_sk[k-1] >> 1;
				end
				rt_m_sk[k]    <= rt_m_sk[k-1];
				rt_neg_sk[k]  <= rt_neg_sk[k-1];
				rt_nz_sk[k]   <= rt_nz_sk[k-1];
				rt_side_sk[k] <= rt_side_sk[k-1];
			end
		end
	end

	// restoring division, one quotient bit per stage; index 0 holds the rounded dividend
	logic [2:0][DW-1:0] dv_rem_sk  [QB+1];
	logic [2:0][QB-1:0] dv_q_sk    [QB+1];
	logic [RW-1:0]      dv_r_sk    [QB+1];
	logic [2:0]         dv_neg_sk  [QB+1];
	logic               dv_nz_sk   [QB+1];
	logic [SW-1:0]      dv_side_sk [QB+1];
	logic               dv_vld_sk  [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_sk[0] <= 1'b0;
		end else if (en) begin
			dv_vld_sk[0] <= rt_vld_sk[SQN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_sk[0][i] <= (DW'(rt_m_sk[SQN][i]) << F)
					+ DW'(rt_r_sk[SQN][RW-1:0] >> 1);
			end
			dv_q_sk[0]    <= '0;
			dv_r_sk[0]    <= rt_r_sk[SQN][RW-1:0];
			dv_neg_sk[0]  <= rt_neg_sk[SQN];
			dv_nz_sk[0]   <= rt_nz_sk[SQN];
			dv_side_sk[0] <= rt_side_sk[SQN];
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int SH = QB - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sk[j] <= 1'b0;
			end else if (en) begin
				dv_vld_sk[j] <= dv_vld_sk[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_sk[j-1][i] >= (DW'(dv_r_sk[j-1]) << SH)) begin
						dv_rem_sk[j][i] <= dv_rem_sk[j-1][i] - (DW'(dv_r_sk[j-1]) << SH);
						dv_q_sk[j][i]   <= dv_q_sk[j-1][i] | (QB'(1) << SH);
					end else begin
						dv_rem_sk[j][i] <= dv_rem_sk[j-1][i];
						dv_q_sk[j][i]   <= dv_q_sk[j-1][i];
					end
				end
				dv_r_sk[j]    <= dv_r_sk[j-1];
				dv_neg_sk[j]  <= dv_neg_sk[j-1];
				dv_nz_sk[j]   <= dv_nz_sk[j-1];
				dv_side_sk[j] <= dv_side_sk[j-1];
			end
		end
	end

	// sign back on; a zero vector stays zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= dv_vld_sk[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!dv_nz_sk[QB]) begin
					out_vec[i] <= '0;
				end else if (dv_neg_sk[QB][i]) begin
					out_vec[i] <= -OW'(dv_q_sk[QB][i]);
				end else begin
					out_vec[i] <= OW'(dv_q_sk[QB][i]);
				end
			end
			ok       <= dv_nz_sk[QB];
			out_side <= dv_side_sk[QB];
		end
	end

endmodule

// ----- rtl/lookat_view_matrix.sv -----
// look-at view matrix: camera set-up beats in, four matrix row beats out
//
// cam channel: one beat carries eye, target and up vectors, signed fixed
// point with FRAC_BITS fraction bits. row channel: four beats per camera
// beat, rows 0 to 3 in order; row 3 is 0 0 0 1 and has last_row set.
// degenerate is the same on all four rows and flags a zero-length forward
// or right axis (eye equal to target, or up zero or parallel to forward).
// pipeline: each normalizer holds a 32-step square root and a
// (FRAC_BITS+1)-step divider, one step per stage.
// throughput: camera beats are limited by the single row channel, which
// moves one row a cycle while row_ready is high; the pipeline takes a beat
// a cycle only while the output register is empty, and once rows wait it
// steps once per drained matrix.
// stall: when the output register holds rows that are not yet taken, the
// whole pipeline freezes with cam_ready low; nothing is dropped or repeated.
// reset: all valid bits clear, no row pending, cam_ready high.
module lookat_view_matrix #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cam_valid,
	output logic           cam_ready,
	input  lvm_pkg::cam_t  cam,
	output logic           row_valid,
	input  logic           row_ready,
	output lvm_pkg::row_t  row
);

	localparam int Q   = lvm_pkg::Q_W;
	localparam int AW  = FRAC_BITS + 2;        // unit axis component
	localparam int DFW = Q + 1;                // eye minus target
	localparam int PPW = Q + AW;               // up times forward
	localparam int CW  = PPW + 1;              // cross product for right axis
	localparam int YPW = 2 * AW;               // forward times right
	localparam int YDW = YPW + 1;
	localparam int DPW = AW + Q;               // axis times eye
	localparam int DSW = DPW + 2;
	localparam int RMW = DSW - FRAC_BITS;
	localparam int ZSW = 6 * Q;
	localparam int XSW = 3 * Q + 3 * AW + 1;

	logic adv;       // whole pipeline steps
	logic full_q;    // output register holds a matrix
	logic [1:0] row_q;

	// pipeline moves whenever the output register is empty or its last row goes now
	assign adv       = !full_q || (row_ready && row_q == lvm_pkg::ROW_W);
	assign cam_ready = adv;

	// s1: forward direction before normalizing
	logic                  vld_s1;
	logic signed [DFW-1:0] d_s1 [3];
	logic [ZSW-1:0]        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cam_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= cam.eye_x - cam.target_x;
			d_s1[1] <= cam.eye_y - cam.target_y;
			d_s1[2] <= cam.eye_z - cam.target_z;
			side_s1 <= {cam.up_z, cam.up_y, cam.up_x, cam.eye_z, cam.eye_y, cam.eye_x};
		end
	end

	// forward axis z
	logic                 zn_vld;
	logic signed [AW-1:0] za_n [3];
	logic                 okz_n;
	logic [ZSW-1:0]       zside_n;

	lvm_norm #(
		.IW (DFW),
		.OW (AW),
		.F  (FRAC_BITS),
		.SW (ZSW)
	) u_norm_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld      (vld_s1),
		.vec      (d_s1),
		.side     (side_s1),
		.out_vld  (zn_vld),
		.out_vec  (za_n),
		.ok       (okz_n),
		.out_side (zside_n)
	);

	logic signed [Q-1:0] ez_c [3];
	logic signed [Q-1:0] uz_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ez_c[i] = zside_n[Q*i +: Q];
			uz_c[i] = zside_n[3*Q + Q*i +: Q];
		end
	end

	// s2: partial products of up cross forward
	logic                  vld_s2;
	logic signed [PPW-1:0] cp_s2 [6];
	logic signed [AW-1:0]  za_s2 [3];
	logic signed [Q-1:0]   e_s2 [3];
	logic                  okz_s2;

	// s3: right axis before normalizing
	logic                  vld_s3;
	logic signed [CW-1:0]  c_s3 [3];
	logic signed [AW-1:0]  za_s3 [3];
	logic signed [Q-1:0]   e_s3 [3];
	logic                  okz_s3;
	logic [XSW-1:0]        side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= zn_vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s2[0] <= uz_c[1] * za_n[2];
			cp_s2[1] <= uz_c[2] * za_n[1];
			cp_s2[2] <= uz_c[2] * za_n[0];
			cp_s2[3] <= uz_c[0] * za_n[2];
			cp_s2[4] <= uz_c[0] * za_n[1];
			cp_s2[5] <= uz_c[1] * za_n[0];
			za_s2    <= za_n;
			e_s2     <= ez_c;
			okz_s2   <= okz_n;
			c_s3[0]  <= cp_s2[0] - cp_s2[1];
			c_s3[1]  <= cp_s2[2] - cp_s2[3];
			c_s3[2]  <= cp_s2[4] - cp_s2[5];
			za_s3    <= za_s2;
			e_s3     <= e_s2;
			okz_s3   <= okz_s2;
		end
	end

	assign side_s3 = {okz_s3, za_s3[2], za_s3[1], za_s3[0], e_s3[2], e_s3[1], e_s3[0]};

	// right axis x
	logic                 xn_vld;
	logic signed [AW-1:0] xa_n [3];
	logic                 okx_n;
	logic [XSW-1:0]       xside_n;

	lvm_norm #(
		.IW (CW),
		.OW (AW),
		.F  (FRAC_BITS),
		.SW (XSW)
	) u_norm_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld      (vld_s3),
		.vec      (c_s3),
		.side     (side_s3),
		.out_vld  (xn_vld),
		.out_vec  (xa_n),
		.ok       (okx_n),
		.out_side (xside_n)
	);

	logic signed [Q-1:0]  ex_c [3];
	logic signed [AW-1:0] zx_c [3];
	logic                 okzx_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ex_c[i] = xside_n[Q*i +: Q];
			zx_c[i] = xside_n[3*Q + AW*i +: AW];
		end
		okzx_c = xside_n[XSW-1];
	end

	// s4..s6: true up axis y = z cross x, rounded back to FRAC_BITS
	logic                  vld_s4, vld_s5, vld_s6;
	logic signed [YPW-1:0] yp_s4 [6];
	logic signed [YDW-1:0] yd_s5 [3];
	logic signed [AW-1:0]  ya_s6 [3];
	logic signed [AW-1:0]  xa_s4 [3], xa_s5 [3], xa_s6 [3];
	logic signed [AW-1:0]  za_s4 [3], za_s5 [3], za_s6 [3];
	logic signed [Q-1:0]   e_s4 [3], e_s5 [3], e_s6 [3];
	logic                  dg_s4, dg_s5, dg_s6;
	logic [YDW-1:0]        ymag_c [3];
	logic [YDW-1:0]        yrm_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ymag_c[i] = yd_s5[i][YDW-1] ? YDW'(-yd_s5[i]) : YDW'(yd_s5[i]);
			yrm_c[i]  = (ymag_c[i] + (YDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= xn_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yp_s4[0] <= zx_c[1] * xa_n[2];
			yp_s4[1] <= zx_c[2] * xa_n[1];
			yp_s4[2] <= zx_c[2] * xa_n[0];
			yp_s4[3] <= zx_c[0] * xa_n[2];
			yp_s4[4] <= zx_c[0] * xa_n[1];
			yp_s4[5] <= zx_c[1] * xa_n[0];
			xa_s4    <= xa_n;
			za_s4    <= zx_c;
			e_s4     <= ex_c;
			dg_s4    <= !okzx_c || !okx_n;
			yd_s5[0] <= yp_s4[0] - yp_s4[1];
			yd_s5[1] <= yp_s4[2] - yp_s4[3];
			yd_s5[2] <= yp_s4[4] - yp_s4[5];
			xa_s5    <= xa_s4;
			za_s5    <= za_s4;
			e_s5     <= e_s4;
			dg_s5    <= dg_s4;
			for (int i = 0; i < 3; i++) begin
				ya_s6[i] <= yd_s5[i][YDW-1] ? -AW'(yrm_c[i]) : AW'(yrm_c[i]);
			end
			xa_s6    <= xa_s5;
			za_s6    <= za_s5;
			e_s6     <= e_s5;
			dg_s6    <= dg_s5;
		end
	end

	// s7..s10: translation column, -(axis . eye) rounded and saturated
	logic signed [AW-1:0]  ax_c  [3][3];
	logic                  vld_s7, vld_s8, vld_s9, vld_s10;
	logic signed [DPW-1:0] dp_s7 [3][3];
	logic signed [DSW-1:0] ds_s8 [3];
	logic [RMW-1:0]        rm_s9 [3];
	logic [2:0]            rneg_s9;
	logic signed [Q-1:0]   tr_s10 [3];
	logic signed [AW-1:0]  ax_s7 [3][3], ax_s8 [3][3], ax_s9 [3][3], ax_s10 [3][3];
	logic                  dg_s7, dg_s8, dg_s9, dg_s10;
	logic [DSW-1:0]        dmag_c [3];

	always_comb begin
		ax_c[0] = xa_s6;
		ax_c[1] = ya_s6;
		ax_c[2] = za_s6;
		for (int k = 0; k < 3; k++) begin
			dmag_c[k] = ds_s8[k][DSW-1] ? DSW'(-ds_s8[k]) : DSW'(ds_s8[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s7[k][i] <= ax_c[k][i] * e_s6[i];
				end
				ds_s8[k]   <= dp_s7[k][0] + dp_s7[k][1] + dp_s7[k][2];
				rneg_s9[k] <= ds_s8[k][DSW-1];
				rm_s9[k]   <= RMW'((dmag_c[k] + (DSW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
				// negating flips the sign: a negative dot gives a positive entry
				if (rneg_s9[k]) begin
					if (rm_s9[k] > RMW'(64'h7fff_ffff)) begin
						tr_s10[k] <= 32'sh7fff_ffff;
					end else begin
						tr_s10[k] <= rm_s9[k][Q-1:0];
					end
				end else begin
					if (rm_s9[k] > RMW'(64'h8000_0000)) begin
						tr_s10[k] <= 32'sh8000_0000;
					end else begin
						tr_s10[k] <= -rm_s9[k][Q-1:0];
					end
				end
			end
			ax_s7  <= ax_c;
			ax_s8  <= ax_s7;
			ax_s9  <= ax_s8;
			ax_s10 <= ax_s9;
			dg_s7  <= dg_s6;
			dg_s8  <= dg_s7;
			dg_s9  <= dg_s8;
			dg_s10 <= dg_s9;
		end
	end

	// output register: one whole matrix, sent as four row beats
	logic signed [Q-1:0] ent_q [3][3];
	logic signed [Q-1:0] tr_q [3];
	logic                degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= lvm_pkg::ROW_X;
		end else if (adv) begin
			full_q <= vld_s10;
			row_q  <= lvm_pkg::ROW_X;
		end else if (row_ready) begin
			row_q  <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					ent_q[k][i] <= Q'(ax_s10[k][i]);
				end
			end
			tr_q    <= tr_s10;
			degen_q <= dg_s10;
		end
	end

	assign row_valid = full_q;

	always_comb begin
		row.row_index  = row_q;
		row.degenerate = degen_q;
		row.last_row   = 1'b0;
		case (row_q)
			lvm_pkg::ROW_X: begin
				row.col0 = ent_q[0][0];
				row.col1 = ent_q[0][1];
				row.col2 = ent_q[0][2];
				row.col3 = tr_q[0];
			end
			lvm_pkg::ROW_Y: begin
				row.col0 = ent_q[1][0];
				row.col1 = ent_q[1][1];
				row.col2 = ent_q[1][2];
				row.col3 = tr_q[1];
			end
			lvm_pkg::ROW_Z: begin
				row.col0 = ent_q[2][0];
				row.col1 = ent_q[2][1];
				row.col2 = ent_q[2][2];
				row.col3 = tr_q[2];
			end
			default: begin
				row.col0     = '0;
				row.col1     = '0;
				row.col2     = '0;
				row.col3     = Q'(1) << FRAC_BITS;
				row.last_row = 1'b1;
			end
		endcase
	end

	// rows of one matrix go out in order with no gap in numbering
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && row_q != lvm_pkg::ROW_W)
		|=> (row_valid && row_q == $past(row_q) + 2'd1))
		else $error("row beats out of order");

	// degenerate flag is shared by all rows of one matrix
	a_degen_same: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && row_q != lvm_pkg::ROW_W)
		|=> (row.degenerate == $past(row.degenerate)))
		else $error("degenerate changed within a matrix");

	// a refused row beat keeps its row number and camera input stays blocked
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && !row_ready)
		|=> (row_valid && row_q == $past(row_q) && $past(!cam_ready)))
		else $error("row beat lost during stall");

endmodule

// ----- dv/tb_lookat_view_matrix.sv -----
// look-at view matrix testbench: directed and random camera beats, row beats checked in order
`timescale 1ns / 100ps

module tb_lookat_view_matrix;

	localparam int FB          = 16;
	localparam int LATENCY     = 93 + 2 * FB;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cam_valid = 1'b0;
	logic cam_ready;
	lvm_pkg::cam_t cam = '0;
	logic row_valid;
	logic row_ready = 1'b0;
	lvm_pkg::row_t row;

	lookat_view_matrix #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cam_valid(cam_valid), .cam_ready(cam_ready), .cam(cam),
		.row_valid(row_valid), .row_ready(row_ready), .row(row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// camera beats waiting to be driven, matrix rows waiting to arrive
	lvm_pkg::cam_t cam_pending[$];
	lvm_pkg::row_t rows_due[$];
	int   errors = 0;
	int   cams_sent = 0;
	int   rows_seen = 0;
	int   degen_seen = 0;
	int   idle_pct = 30;
	int   quiet_cycles = 0;
	logic stim_done = 1'b0;

	// magnitude of a 64-bit signed value as unsigned
	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// shift right by FB, rounding half away from zero
	function automatic logic signed [63:0] shr_round(input logic signed [63:0] v);
		logic [63:0] m;
		m = (abs64(v) + (64'd1 << (FB - 1))) >> FB;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector in fixed point; returns 0 for a zero-length input
	function automatic bit unit_vec(input logic signed [63:0] v[3],
			output logic signed [63:0] u[3]);
		logic [63:0] m[3];
		logic [63:0] big, sum, r, q;
		for (int i = 0; i < 3; i++) m[i] = abs64(v[i]);
		big = m[0];
		if (m[1] > big) big = m[1];
		if (m[2] > big) big = m[2];
		if (big == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return 1'b0;
		end
		while (big >= (64'd1 << 30)) begin
			big = big >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (big < (64'd1 << 29)) begin
			big = big << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + r / 2) / r;
			u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
		return 1'b1;
	endfunction

	// works out the four view matrix rows of one camera beat
	task automatic predict_view_rows(input lvm_pkg::cam_t c);
		logic signed [63:0] e[3], d[3], up[3], cr[3], xa[3], ya[3], za[3], ax[3];
		logic signed [63:0] dot;
		bit okz, okx, degen;
		lvm_pkg::row_t r;
		e = '{64'(c.eye_x), 64'(c.eye_y), 64'(c.eye_z)};
		d = '{e[0] - 64'(c.target_x), e[1] - 64'(c.target_y), e[2] - 64'(c.target_z)};
		up = '{64'(c.up_x), 64'(c.up_y), 64'(c.up_z)};
		okz = unit_vec(d, za);
		cr[0] = up[1] * za[2] - up[2] * za[1];
		cr[1] = up[2] * za[0] - up[0] * za[2];
		cr[2] = up[0] * za[1] - up[1] * za[0];
		okx = unit_vec(cr, xa);
		ya[0] = shr_round(za[1] * xa[2] - za[2] * xa[1]);
		ya[1] = shr_round(za[2] * xa[0] - za[0] * xa[2]);
		ya[2] = shr_round(za[0] * xa[1] - za[1] * xa[0]);
		degen = !okz || !okx;
		for (int k = 0; k < 3; k++) begin
			if (k == 0) ax = xa;
			else if (k == 1) ax = ya;
			else ax = za;
			dot = ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2];
			r.row_index = (k == 0) ? lvm_pkg::ROW_X : (k == 1) ? lvm_pkg::ROW_Y : lvm_pkg::ROW_Z;
			r.col0 = 32'(clamp32(ax[0]));
			r.col1 = 32'(clamp32(ax[1]));
			r.col2 = 32'(clamp32(ax[2]));
			r.col3 = 32'(clamp32(-shr_round(dot)));
			r.last_row = 1'b0;
			r.degenerate = degen;
			rows_due.push_back(r);
		end
		r = '0;
		r.row_index = lvm_pkg::ROW_W;
		r.col3 = 32'(1) << FB;
		r.last_row = 1'b1;
		r.degenerate = degen;
		rows_due.push_back(r);
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7fff_fffc | $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
		endcase
	endfunction

	function automatic lvm_pkg::cam_t mk_cam(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
		lvm_pkg::cam_t c;
		c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
		c.target_x = tx; c.target_y = ty; c.target_z = tz;
		c.up_x = ux; c.up_y = uy; c.up_z = uz;
		return c;
	endfunction

	localparam int ONE  = 1 << FB;
	localparam int QMAX = 32'h7fff_ffff;
	localparam int QMIN = 32'h8000_0000;

	initial begin
		lvm_pkg::cam_t c;
		// directed: plain camera, degenerate cases, field extremes
		cam_pending.push_back(mk_cam(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
		cam_pending.push_back(mk_cam(ONE, 2 * ONE, 3 * ONE, -ONE, 0, 0, 0, 0, ONE));
		cam_pending.push_back(mk_cam(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
		cam_pending.push_back(mk_cam(0, 0, ONE, 0, 0, 0, 0, 0, 0));
		cam_pending.push_back(mk_cam(0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE));
		cam_pending.push_back(mk_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
		cam_pending.push_back(mk_cam(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX, QMIN, QMAX));
		cam_pending.push_back(mk_cam(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMIN, QMAX, QMIN));
		cam_pending.push_back(mk_cam(QMAX, QMIN, 0, 0, 0, QMAX, 1, 0, 0));
		cam_pending.push_back(mk_cam(1, 0, 0, 0, 0, 0, 0, 1, 0));
		cam_pending.push_back(mk_cam(-1, -1, -1, 0, 0, 0, -1, 0, 1));
		cam_pending.push_back(mk_cam(QMAX, QMAX, QMAX, 0, 0, 0, -1, -1, -1));
		cam_pending.push_back(mk_cam(QMIN, 0, 0, QMAX, 0, 0, 0, QMIN, 0));
		cam_pending.push_back(mk_cam(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		// random: mostly well-formed cameras, some with parallel up or eye on target
		for (int n = 0; n < 86; n++) begin
			c = mk_cam(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
				rand_q(), rand_q(), rand_q());
			case ($urandom_range(0, 9))
				0: begin
					c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z;
				end
				1: begin
					c.up_x = c.eye_x - c.target_x;
					c.up_y = c.eye_y - c.target_y;
					c.up_z = c.eye_z - c.target_z;
				end
				default: ;
			endcase
			cam_pending.push_back(c);
		end
	end

	// driver: valid held with stable payload until the beat is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (cam_valid && cam_ready) begin
				predict_view_rows(cam);
				cams_sent <= cams_sent + 1;
			end
			if (!cam_valid || cam_ready) begin
				if (cam_pending.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
					cam_valid <= 1'b1;
					cam <= cam_pending.pop_front();
				end else begin
					cam_valid <= 1'b0;
				end
			end
			row_ready <= ($urandom_range(1, 100) > idle_pct);
		end
	end

	// monitor: each row beat against the oldest prediction
	always @(posedge clk) begin
		lvm_pkg::row_t want;
		if (arst_n && row_valid && row_ready) begin
			rows_seen <= rows_seen + 1;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row beat %p", $time, row);
				errors <= errors + 1;
			end else begin
				want = rows_due.pop_front();
				if (row.last_row && row.degenerate) degen_seen <= degen_seen + 1;
				if (row !== want) begin
					$display("%0t: row mismatch expected %p actual %p", $time, want, row);
					errors <= errors + 1;
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((cam_valid && cam_ready) || (row_valid && row_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !stim_done) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// random idling first, then a long stretch with none, then idling again
		repeat (150) @(posedge clk);
		idle_pct = 0;
		repeat (400) @(posedge clk);
		idle_pct = 30;
		while (cam_pending.size() != 0 || cam_valid || rows_due.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		stim_done = 1'b1;
		$display("covered %0d camera beats, %0d row beats, %0d degenerate matrices",
			cams_sent, rows_seen, degen_seen);
		if (errors == 0 && rows_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lvm_pkg.sv
rtl/lvm_norm.sv
rtl/lookat_view_matrix.sv
dv/tb_lookat_view_matrix.sv
